### hw/rtl/bdeq_pkg.sv
// Package for the byte deque: sizes, command and status codes, state type
// and ring address helpers. No dependencies.
`timescale 1ns / 1ps
package bdeq_pkg;

	localparam int DEPTH  = 64;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int PAIR_W = CNT_W - 1;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [PAIR_W-1:0] pair_t;

	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_CHECK      = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_POP_EMPTY = 2'd1,
		STAT_PUSH_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_CHECK
	} state_t;

	localparam logic [7:0] NUL_BYTE = 8'h00;

	function automatic addr_t addr_inc(input addr_t a);
		return (a == addr_t'(DEPTH - 1)) ? '0 : addr_t'(a + addr_t'(1));
	endfunction

	function automatic addr_t addr_dec(input addr_t a);
		return (a == '0) ? addr_t'(DEPTH - 1) : addr_t'(a - addr_t'(1));
	endfunction

	function automatic addr_t slot_add(input addr_t base, input cnt_t off);
		logic [CNT_W:0] sum;
		sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
		if (sum >= (CNT_W + 1)'(DEPTH)) begin
			sum = sum - (CNT_W + 1)'(DEPTH);
		end
		return sum[ADDR_W-1:0];
	endfunction

endpackage

### hw/rtl/bdeq_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module bdeq_ram #(
	parameter int WIDTH   = 8,
	parameter int DEPTH_P = 64
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH_P)-1:0] waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic [$clog2(DEPTH_P)-1:0] ra_addr,
	output logic [WIDTH-1:0]           ra_data,
	input  logic [$clog2(DEPTH_P)-1:0] rb_addr,
	output logic [WIDTH-1:0]           rb_data
);

	logic [WIDTH-1:0] mem [DEPTH_P];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		ra_data <= mem[ra_addr];
		rb_data <= mem[rb_addr];
	end

endmodule

### hw/rtl/byte_deque_with_symmetry_check.sv
// Top level of the byte deque with symmetry check.
// Depends on bdeq_pkg and bdeq_ram.
`timescale 1ns / 1ps
// The deque holds up to DEPTH bytes in a ring buffer in one RAM with two
// registered read ports. One transaction is worked on at a time and gives
// exactly one result transaction through an output register. Pushes, pops on
// an empty deque, checks on fewer than two entries and unused codes give their
// result from the idle state; a pop gives the registered read data from the
// pop state; a check on n entries compares up to n/2 pairs of entries, one per
// cycle through the two read ports. The RAM needs no clearing after reset.
module byte_deque_with_symmetry_check
	import bdeq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] command,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] popped_byte,
	output logic [1:0] status,
	output logic       is_symmetric,
	output logic       is_empty
);

	state_t  state_q, state_d;
	addr_t   front_q, front_d;
	cnt_t    count_q, count_d;
	addr_t   lo_q, lo_d;
	addr_t   hi_q, hi_d;
	pair_t   pairs_q, pairs_d;
	logic    out_valid_q;
	logic [7:0] popped_q;
	status_t status_q;
	logic    sym_q;
	logic    empty_q;

	logic       accept;
	logic       full;
	addr_t      back_slot;
	addr_t      last_slot;
	logic       ld;
	logic [7:0] ld_byte;
	status_t    ld_status;
	logic       ld_sym;
	logic       ld_empty;
	logic       we;
	addr_t      waddr;
	addr_t      ra_addr;
	addr_t      rb_addr;
	logic [7:0] ra_data;
	logic [7:0] rb_data;

	bdeq_ram #(
		.WIDTH   (8),
		.DEPTH_P (DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (data_byte),
		.ra_addr (ra_addr),
		.ra_data (ra_data),
		.rb_addr (rb_addr),
		.rb_data (rb_data)
	);

	assign in_stall  = !(state_q == S_IDLE && (!out_valid_q || !out_stall));
	assign accept    = in_valid && !in_stall;
	assign full      = (count_q >= cnt_t'(DEPTH));
	assign back_slot = slot_add(front_q, count_q);
	assign last_slot = slot_add(front_q, cnt_t'(count_q - cnt_t'(1)));

	always_comb begin
		state_d   = state_q;
		front_d   = front_q;
		count_d   = count_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		pairs_d   = pairs_q;
		ld        = 1'b0;
		ld_byte   = NUL_BYTE;
		ld_status = STAT_OK;
		ld_sym    = 1'b0;
		we        = 1'b0;
		waddr     = front_q;
		ra_addr   = lo_q;
		rb_addr   = hi_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd_t'(command))
						CMD_PUSH_FRONT: begin
							ld = 1'b1;
							if (full) begin
								ld_status = STAT_PUSH_FULL;
							end else begin
								front_d = addr_dec(front_q);
								we      = 1'b1;
								waddr   = front_d;
								count_d = cnt_t'(count_q + cnt_t'(1));
							end
						end
						CMD_PUSH_BACK: begin
							ld = 1'b1;
							if (full) begin
								ld_status = STAT_PUSH_FULL;
							end else begin
								we      = 1'b1;
								waddr   = back_slot;
								count_d = cnt_t'(count_q + cnt_t'(1));
							end
						end
						CMD_POP_FRONT: begin
							if (count_q == '0) begin
								ld        = 1'b1;
								ld_status = STAT_POP_EMPTY;
							end else begin
								ra_addr = front_q;
								front_d = addr_inc(front_q);
								count_d = cnt_t'(count_q - cnt_t'(1));
								state_d = S_POP;
							end
						end
						CMD_POP_BACK: begin
							if (count_q == '0) begin
								ld        = 1'b1;
								ld_status = STAT_POP_EMPTY;
							end else begin
								ra_addr = last_slot;
								count_d = cnt_t'(count_q - cnt_t'(1));
								state_d = S_POP;
							end
						end
						CMD_CHECK: begin
							if (count_q < cnt_t'(2)) begin
								ld     = 1'b1;
								ld_sym = (count_q == cnt_t'(1));
							end else begin
								lo_d    = front_q;
								hi_d    = last_slot;
								pairs_d = count_q[CNT_W-1:1];
								ra_addr = front_q;
								rb_addr = last_slot;
								state_d = S_CHECK;
							end
						end
						default: begin
							ld = 1'b1;
						end
					endcase
				end
			end
			S_POP: begin
				ld      = 1'b1;
				ld_byte = ra_data;
				state_d = S_IDLE;
			end
			S_CHECK: begin
				if (ra_data != rb_data) begin
					ld      = 1'b1;
					state_d = S_IDLE;
				end else if (pairs_q == pair_t'(1)) begin
					ld      = 1'b1;
					ld_sym  = 1'b1;
					state_d = S_IDLE;
				end else begin
					lo_d    = addr_inc(lo_q);
					hi_d    = addr_dec(hi_q);
					pairs_d = pair_t'(pairs_q - pair_t'(1));
					ra_addr = lo_d;
					rb_addr = hi_d;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		ld_empty = (count_d == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			front_q     <= front_d;
			count_q     <= count_d;
			out_valid_q <= ld || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		lo_q    <= lo_d;
		hi_q    <= hi_d;
		pairs_q <= pairs_d;
		if (ld) begin
			popped_q <= ld_byte;
			status_q <= ld_status;
			sym_q    <= ld_sym;
			empty_q  <= ld_empty;
		end
	end

	assign out_valid    = out_valid_q;
	assign popped_byte  = popped_q;
	assign status       = status_q;
	assign is_symmetric = sym_q;
	assign is_empty     = empty_q;

endmodule
